[rtl/core/mhpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mhpq_pkg;

	typedef struct packed {
		logic signed [15:0] pri;
		logic [31:0]        lat;
		logic [31:0]        tag;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	localparam logic [1:0] OP_APPEND  = 2'd0;
	localparam logic [1:0] OP_HEAPIFY = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [6:0] LIMIT_RESET = 7'd64;

	function automatic logic outranks(input entry_t a, input entry_t b);
		logic res;
		if (a.pri != b.pri) begin
			res = (a.pri > b.pri);
		end else begin
			res = (a.lat < b.lat);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[rtl/core/mhpq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/max_heap_priority_queue.sv]
`timescale 1ns / 1ps
// Steps: append, no-op, remove on empty and heapify of fewer than two entries go from idle
// to done; a remove reads root and last entry (RROOT, RLAST, RCAP), then sifts down via SIFT,
// LEFT, RIGHT (if a right child exists) and MOVE at each node, writing in SIFT at a leaf;
// heapify loads each index from (count-1)/2 down to 0 (HRD, HCAP) and sifts it. One request
// at a time, the next accepted the cycle after the result register loads; one RAM read and write.
// Reset clears the count, the state and the result valid flag; the limit returns to 64.
`default_nettype none
module max_heap_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] entry_priority,
	input  wire logic [31:0]        entry_latency,
	input  wire logic [31:0]        entry_tag,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic signed [15:0]      out_priority,
	output logic [31:0]             out_latency,
	output logic [31:0]             out_tag,
	output logic [6:0]              entry_count,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [6:0]         cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;
	localparam int XW = CW + 7;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RROOT = 11'b00000000010,
		S_RLAST = 11'b00000000100,
		S_RCAP  = 11'b00000001000,
		S_SIFT  = 11'b00000010000,
		S_LEFT  = 11'b00000100000,
		S_RIGHT = 11'b00001000000,
		S_MOVE  = 11'b00010000000,
		S_HRD   = 11'b00100000000,
		S_HCAP  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [6:0]            limit_q;
	logic                  heap_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         hi_q;
	logic [AW-1:0]         best_idx_q;
	mhpq_pkg::entry_t      cur_q;
	mhpq_pkg::entry_t      best_q;
	mhpq_pkg::entry_t      res_q;
	logic [1:0]            res_status_q;
	logic                  out_valid_q;
	mhpq_pkg::entry_t      out_q;
	logic [1:0]            out_status_q;
	logic [6:0]            out_count_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	mhpq_pkg::entry_t      wdata;
	logic [AW-1:0]         raddr;
	logic [mhpq_pkg::EntryW-1:0] rdata_raw;
	mhpq_pkg::entry_t      rdata;

	logic                  in_acc;
	logic [XW-1:0]         cnt_ext;
	logic                  full;
	logic [IW-1:0]         left_w;
	logic [IW-1:0]         right_w;
	logic                  has_left;
	logic                  has_right;
	logic [CW-1:0]         count_m1;

	mhpq_ram #(
		.WIDTH(mhpq_pkg::EntryW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rdata     = mhpq_pkg::entry_t'(rdata_raw);
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cnt_ext   = XW'(count_q);
	assign full      = (cnt_ext >= XW'(limit_q)) || (cnt_ext >= XW'(CAPACITY));
	assign left_w    = IW'({pos_q, 1'b1});
	assign right_w   = IW'({pos_q, 1'b0}) + IW'(2);
	assign has_left  = left_w < IW'(count_q);
	assign has_right = right_w < IW'(count_q);
	assign count_m1  = count_q - CW'(1);

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_priority = out_q.pri;
	assign out_latency  = out_q.lat;
	assign out_tag      = out_q.tag;
	assign entry_count  = out_count_q;

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		raddr = pos_q;
		case (state_q)
			S_IDLE: begin
				waddr = AW'(count_q);
				wdata = '{pri: entry_priority, lat: entry_latency, tag: entry_tag};
				we    = in_acc && (opcode == mhpq_pkg::OP_APPEND) && !full;
			end
			S_RROOT: raddr = '0;
			S_RLAST: raddr = AW'(count_m1);
			S_SIFT: begin
				raddr = left_w[AW-1:0];
				we    = !has_left;
			end
			S_LEFT:  raddr = right_w[AW-1:0];
			S_MOVE: begin
				we    = 1'b1;
				wdata = (best_idx_q == pos_q) ? cur_q : best_q;
			end
			S_HRD:   raddr = hi_q;
			default: raddr = pos_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			limit_q     <= mhpq_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
			heap_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_q <= '0;
						case (opcode)
							mhpq_pkg::OP_APPEND: begin
								heap_q  <= 1'b0;
								state_q <= S_DONE;
								if (full) begin
									res_status_q <= mhpq_pkg::ST_FULL;
								end else begin
									res_status_q <= mhpq_pkg::ST_DONE;
									count_q      <= count_q + CW'(1);
								end
							end
							mhpq_pkg::OP_HEAPIFY: begin
								res_status_q <= mhpq_pkg::ST_DONE;
								if (count_q > CW'(1)) begin
									heap_q  <= 1'b1;
									hi_q    <= AW'(count_m1 >> 1);
									state_q <= S_HRD;
								end else begin
									heap_q  <= 1'b0;
									state_q <= S_DONE;
								end
							end
							mhpq_pkg::OP_REMOVE: begin
								heap_q <= 1'b0;
								if (count_q == '0) begin
									res_status_q <= mhpq_pkg::ST_EMPTY;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= mhpq_pkg::ST_DONE;
									state_q      <= S_RROOT;
								end
							end
							default: begin
								heap_q       <= 1'b0;
								res_status_q <= mhpq_pkg::ST_DONE;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_RROOT: state_q <= S_RLAST;
				S_RLAST: begin
					res_q   <= rdata;
					state_q <= S_RCAP;
				end
				S_RCAP: begin
					cur_q   <= rdata;
					pos_q   <= '0;
					count_q <= count_m1;
					state_q <= (count_m1 == '0) ? S_DONE : S_SIFT;
				end
				S_SIFT: begin
					if (has_left) begin
						state_q <= S_LEFT;
					end else if (heap_q && hi_q != '0) begin
						hi_q    <= hi_q - AW'(1);
						state_q <= S_HRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LEFT: begin
					if (mhpq_pkg::outranks(rdata, cur_q)) begin
						best_q     <= rdata;
						best_idx_q <= left_w[AW-1:0];
					end else begin
						best_q     <= cur_q;
						best_idx_q <= pos_q;
					end
					state_q <= has_right ? S_RIGHT : S_MOVE;
				end
				S_RIGHT: begin
					if (mhpq_pkg::outranks(rdata, best_q)) begin
						best_q     <= rdata;
						best_idx_q <= right_w[AW-1:0];
					end
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					if (best_idx_q != pos_q) begin
						pos_q   <= best_idx_q;
						state_q <= S_SIFT;
					end else if (heap_q && hi_q != '0) begin
						hi_q    <= hi_q - AW'(1);
						state_q <= S_HRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_HRD: state_q <= S_HCAP;
				S_HCAP: begin
					cur_q   <= rdata;
					pos_q   <= hi_q;
					state_q <= S_SIFT;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_q        <= res_q;
						out_status_q <= res_status_q;
						out_count_q  <= cnt_ext[6:0];
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
		else $error("entry count moved by more than one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("request accepted without leaving idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");
`endif

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int CAP = 64;
	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int WATCH_LIMIT = 6000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = OP_IDLE;
	logic signed [15:0] entry_priority = '0;
	logic [31:0] entry_latency = '0;
	logic [31:0] entry_tag = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [15:0] out_priority;
	logic [31:0] out_latency;
	logic [31:0] out_tag;
	logic [6:0] entry_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;

	typedef struct packed {
		logic [1:0] st;
		mhpq_pkg::entry_t ent;
		logic [6:0] cnt;
	} outcome_t;

	mhpq_pkg::entry_t heap_mem [CAP];
	int unsigned heap_count = 0;
	int unsigned limit_reg = 64;
	outcome_t pending_outcomes [$];
	int errors = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;

	max_heap_priority_queue #(.CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .entry_priority(entry_priority),
		.entry_latency(entry_latency), .entry_tag(entry_tag),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_priority(out_priority),
		.out_latency(out_latency), .out_tag(out_tag),
		.entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit ranks_above(mhpq_pkg::entry_t a, mhpq_pkg::entry_t b);
		if (a.pri != b.pri) begin
			return a.pri > b.pri;
		end
		return a.lat < b.lat;
	endfunction

	function automatic void sift_from(int unsigned pos);
		int unsigned best;
		mhpq_pkg::entry_t t;
		forever begin
			best = pos;
			if (2 * pos + 1 < heap_count && ranks_above(heap_mem[2 * pos + 1], heap_mem[best])) begin
				best = 2 * pos + 1;
			end
			if (2 * pos + 2 < heap_count && ranks_above(heap_mem[2 * pos + 2], heap_mem[best])) begin
				best = 2 * pos + 2;
			end
			if (best == pos) begin
				return;
			end
			t = heap_mem[pos];
			heap_mem[pos] = heap_mem[best];
			heap_mem[best] = t;
			pos = best;
		end
	endfunction

	function automatic outcome_t apply_request(logic [1:0] op, mhpq_pkg::entry_t e);
		outcome_t o;
		int unsigned lim;
		int i;
		o = '0;
		lim = (limit_reg > CAP) ? CAP : limit_reg;
		case (op)
			mhpq_pkg::OP_APPEND: begin
				if (heap_count >= lim) begin
					o.st = mhpq_pkg::ST_FULL;
				end else begin
					heap_mem[heap_count] = e;
					heap_count++;
				end
			end
			mhpq_pkg::OP_HEAPIFY: begin
				if (heap_count > 1) begin
					for (i = int'((heap_count - 1) / 2); i >= 0; i--) begin
						sift_from(i);
					end
				end
			end
			mhpq_pkg::OP_REMOVE: begin
				if (heap_count == 0) begin
					o.st = mhpq_pkg::ST_EMPTY;
				end else begin
					o.ent = heap_mem[0];
					heap_mem[0] = heap_mem[heap_count - 1];
					heap_count--;
					sift_from(0);
				end
			end
			default: ;
		endcase
		o.st = o.st;
		o.cnt = heap_count[6:0];
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (in_valid && !in_stall || out_valid && !out_stall || cfg_valid && cfg_ready) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				report("unexpected result", {62'd0, status}, 64'd0);
			end else begin
				w = pending_outcomes.pop_front();
				if (status !== w.st) report("status", 64'(status), 64'(w.st));
				if (out_priority !== w.ent.pri)
					report("priority", 64'(out_priority), 64'(w.ent.pri));
				if (out_latency !== w.ent.lat)
					report("latency", 64'(out_latency), 64'(w.ent.lat));
				if (out_tag !== w.ent.tag) report("tag", 64'(out_tag), 64'(w.ent.tag));
				if (entry_count !== w.cnt) report("count", 64'(entry_count), 64'(w.cnt));
			end
		end
	end

	initial begin
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!stalls_on) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				out_stall <= 1'b0;
			end else begin
				free_left = $urandom_range(0, 12);
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
					$urandom_range(0, 3);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		wait (idle_cycles >= WATCH_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_request(logic [1:0] op, logic [15:0] p, logic [31:0] l, logic [31:0] t);
		mhpq_pkg::entry_t e;
		int gap;
		e.pri = p;
		e.lat = l;
		e.tag = t;
		opcode <= op;
		entry_priority <= p;
		entry_latency <= l;
		entry_tag <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_outcomes.push_back(apply_request(op, e));
		if (gaps_on) begin
			gap = $urandom_range(0, 99);
			gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [6:0] v);
		wait_drained();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = 32'(v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_pri();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3));
			1: return 16'h8000 + 16'($urandom_range(0, 2));
			2: return 16'h7FFF - 16'($urandom_range(0, 2));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_lat();
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom;
	endfunction

	task automatic append_random();
		send_request(mhpq_pkg::OP_APPEND, rand_pri(), rand_lat(), $urandom);
	endtask

	task automatic test_directed();
		send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
		send_request(mhpq_pkg::OP_HEAPIFY, 16'h0, 32'h0, 32'h0);
		send_request(OP_IDLE, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(mhpq_pkg::OP_APPEND, 16'h8000, 32'h0, 32'h0);
		send_request(mhpq_pkg::OP_HEAPIFY, 16'h0, 32'h0, 32'h0);
		send_request(mhpq_pkg::OP_APPEND, 16'h7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(mhpq_pkg::OP_APPEND, 16'h7FFF, 32'h00010000, 32'h12345678);
		send_request(mhpq_pkg::OP_APPEND, 16'h0000, 32'h5, 32'hA5A5A5A5);
		send_request(mhpq_pkg::OP_APPEND, 16'h0000, 32'h5, 32'h5A5A5A5A);
		send_request(mhpq_pkg::OP_APPEND, 16'hFFFF, 32'h0, 32'h1);
		send_request(mhpq_pkg::OP_HEAPIFY, 16'h0, 32'h0, 32'h0);
		repeat (7) send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
	endtask

	task automatic test_limits();
		write_limit(7'd0);
		send_request(mhpq_pkg::OP_APPEND, 16'h1, 32'h1, 32'h1);
		write_limit(7'd127);
		repeat (66) append_random();
		send_request(mhpq_pkg::OP_HEAPIFY, 16'h0, 32'h0, 32'h0);
		write_limit(7'd3);
		send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
		append_random();
		repeat (62) send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
		append_random();
		append_random();
		write_limit(7'd1);
		repeat (3) send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
		append_random();
		append_random();
		send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
		write_limit(7'd64);
	endtask

	task automatic test_backpressure();
		wait_drained();
		gaps_on = 1'b0;
		hold_left = 300;
		repeat (30) append_random();
		send_request(mhpq_pkg::OP_HEAPIFY, 16'h0, 32'h0, 32'h0);
		repeat (31) send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
		gaps_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_random();
		int n;
		int k;
		int r;
		n = 0;
		while (n < 930) begin
			if (n > 500 && n < 620) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end else begin
				gaps_on = 1'b1;
				stalls_on = 1'b1;
			end
			r = $urandom_range(0, 9);
			if (r < 7) begin
				k = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 66) : $urandom_range(0, 12);
				repeat (k) append_random();
				send_request(mhpq_pkg::OP_HEAPIFY, 16'h0, 32'h0, 32'h0);
				repeat (k + $urandom_range(0, 2))
					send_request(mhpq_pkg::OP_REMOVE, 16'h0, 32'h0, 32'h0);
				n += 2 * k + 2;
			end else begin
				repeat (8) begin
					send_request(2'($urandom_range(0, 3)), rand_pri(), rand_lat(), $urandom);
				end
				n += 8;
			end
			if ($urandom_range(0, 40) == 0) begin
				write_limit(7'($urandom_range(1, 70)));
			end
		end
		write_limit(7'd64);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_limits();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_outcomes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
